### design/cpc_pkg.sv
package cpc_pkg;

  // sizing
  localparam int POOL_DEPTH = 64;
  localparam int PAGE_BITS  = 52;
  localparam int ADDR_W     = (POOL_DEPTH > 1) ? $clog2(POOL_DEPTH) : 1;
  localparam int CNT_W      = 7;
  localparam int PAGE_W     = 52;
  localparam int TIME_W     = 64;
  localparam int TOT_W      = 64;
  localparam int STORE_W    = TIME_W + PAGE_W;

  // page numbers are cut to PAGE_BITS before use
  localparam logic [PAGE_W-1:0] PAGE_MASK =
    (PAGE_BITS >= PAGE_W) ? {PAGE_W{1'b1}} :
    ((PAGE_W'(1) << PAGE_BITS) - PAGE_W'(1));

  // input modes
  localparam logic [1:0] MODE_ACQ   = 2'd0;
  localparam logic [1:0] MODE_REL   = 2'd1;
  localparam logic [1:0] MODE_PURGE = 2'd2;

  // result kinds
  localparam logic [1:0] KIND_ACQ    = 2'd0;
  localparam logic [1:0] KIND_REL    = 2'd1;
  localparam logic [1:0] KIND_PURGED = 2'd2;
  localparam logic [1:0] KIND_NONE   = 2'd3;

  // result word
  typedef struct packed {
    logic [1:0]        kind;
    logic              hit;
    logic              to_system;
    logic [PAGE_W-1:0] page;
    logic [CNT_W-1:0]  cached;
    logic [CNT_W-1:0]  seq;
    logic              last;
  } res_t;

endpackage

### design/capped_page_cache_with_idle_purge_top.sv
// Acquire and release: one item at a time; S_OP loads the result into the output
//   register once the output is free, and only then is a new item taken.
// Purge of n cached entries: a sweep through the one shared age compare unit
//   and the two-port entry store, then one word per cycle unless the output stalls.
// Reset (rst_n low, synchronous): count and totals zero, cap 64, output empty;
//   entry contents stay undefined, no clearing pass.
module capped_page_cache_with_idle_purge_top (
  input  logic                        clk,
  input  logic                        rst_n,
  // input channel
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [1:0]                  in_mode,
  input  logic [51:0]                 in_page_number,
  input  logic [63:0]                 in_now_time,
  input  logic [63:0]                 in_max_idle,
  // result channel
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [1:0]                  out_kind,
  output logic                        out_hit,
  output logic                        out_to_system,
  output logic [51:0]                 out_page_out,
  output logic [6:0]                  out_cached_now,
  output logic [6:0]                  out_purge_seq,
  output logic                        out_last,
  output logic [63:0]                 out_reuse_total,
  output logic [63:0]                 out_reject_total,
  output logic [63:0]                 out_purged_total,
  // configuration
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [6:0]                  cfg_data
);

  localparam int AW = cpc_pkg::ADDR_W;
  localparam int CW = cpc_pkg::CNT_W;
  localparam int PW = cpc_pkg::PAGE_W;
  localparam int TW = cpc_pkg::TIME_W;

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_OP     = 4'd1;
  localparam logic [3:0] S_P_RD   = 4'd2;
  localparam logic [3:0] S_P_CMP  = 4'd3;
  localparam logic [3:0] S_P_WR   = 4'd4;
  localparam logic [3:0] S_P_FIN  = 4'd5;
  localparam logic [3:0] S_P_NONE = 4'd6;
  localparam logic [3:0] S_P_EMIT = 4'd7;

  localparam logic [CW-1:0] DEPTH_C = CW'(cpc_pkg::POOL_DEPTH);

  logic [3:0]    state_r, state_nxt;
  logic [1:0]    mode_r, mode_nxt;
  logic [PW-1:0] page_r, page_nxt;
  logic [TW-1:0] now_r, now_nxt;
  logic [TW-1:0] max_r, max_nxt;
  logic          acq_hit_r, acq_hit_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [CW-1:0] cap_r;
  logic [63:0]   reuse_r, reuse_nxt;
  logic [63:0]   reject_r, reject_nxt;
  logic [63:0]   purged_r, purged_nxt;
  logic [CW-1:0] n_r, n_nxt;
  logic [CW-1:0] idx_r, idx_nxt;
  logic [CW-1:0] kept_r, kept_nxt;
  logic [CW-1:0] nrem_r, nrem_nxt;
  logic [CW-1:0] emit_r, emit_nxt;

  logic                 out_valid_r;
  cpc_pkg::res_t        res_r, res_nxt;
  logic [63:0]          tot_reuse_r, tot_reject_r, tot_purged_r;
  logic                 out_load;

  logic                 in_acc, out_free;
  logic [CW-1:0]        cap_eff, cnt_dec, cnt_inc, idx_inc, emit_inc;

  logic                         st_we, st_re;
  logic [AW-1:0]                st_waddr, st_raddr;
  logic [cpc_pkg::STORE_W-1:0]  st_wdata, st_rdata;
  logic                         sp_we, sp_re;
  logic [AW-1:0]                sp_waddr, sp_raddr;
  logic [PW-1:0]                sp_wdata, sp_rdata;
  logic                         age_expired;

  // entry store: {time stamp, page}
  cpc_ram #(
    .WIDTH  (cpc_pkg::STORE_W),
    .DEPTH  (cpc_pkg::POOL_DEPTH),
    .ADDR_W (AW)
  ) u_store (
    .clk   (clk),
    .we    (st_we),
    .waddr (st_waddr),
    .wdata (st_wdata),
    .re    (st_re),
    .raddr (st_raddr),
    .rdata (st_rdata)
  );

  // purged pages in removal order
  cpc_ram #(
    .WIDTH  (PW),
    .DEPTH  (cpc_pkg::POOL_DEPTH),
    .ADDR_W (AW)
  ) u_spill (
    .clk   (clk),
    .we    (sp_we),
    .waddr (sp_waddr),
    .wdata (sp_wdata),
    .re    (sp_re),
    .raddr (sp_raddr),
    .rdata (sp_rdata)
  );

  // shared age compare
  cpc_age_unit u_age (
    .clk       (clk),
    .now_time  (now_r),
    .stamp     (st_rdata[cpc_pkg::STORE_W-1:PW]),
    .limit     (max_r),
    .expired_r (age_expired)
  );

  assign in_stall  = (state_r != S_IDLE);
  assign cfg_ready = 1'b1;
  assign in_acc    = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;
  assign cap_eff   = (cap_r < DEPTH_C) ? cap_r : DEPTH_C;
  assign cnt_dec   = count_r - CW'(1);
  assign cnt_inc   = count_r + CW'(1);
  assign idx_inc   = idx_r + CW'(1);
  assign emit_inc  = emit_r + CW'(1);

  // sequencer
  always_comb begin
    state_nxt   = state_r;
    mode_nxt    = mode_r;
    page_nxt    = page_r;
    now_nxt     = now_r;
    max_nxt     = max_r;
    acq_hit_nxt = acq_hit_r;
    count_nxt   = count_r;
    reuse_nxt   = reuse_r;
    reject_nxt  = reject_r;
    purged_nxt  = purged_r;
    n_nxt       = n_r;
    idx_nxt     = idx_r;
    kept_nxt    = kept_r;
    nrem_nxt    = nrem_r;
    emit_nxt    = emit_r;
    st_we       = 1'b0;
    st_waddr    = '0;
    st_wdata    = st_rdata;
    st_re       = 1'b0;
    st_raddr    = '0;
    sp_we       = 1'b0;
    sp_waddr    = nrem_r[AW-1:0];
    sp_wdata    = st_rdata[PW-1:0];
    sp_re       = 1'b0;
    sp_raddr    = '0;
    out_load    = 1'b0;
    res_nxt     = '0;
    res_nxt.last   = 1'b1;
    res_nxt.cached = count_r;

    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          mode_nxt = in_mode;
          page_nxt = in_page_number & cpc_pkg::PAGE_MASK;
          now_nxt  = in_now_time;
          max_nxt  = in_max_idle;
          unique case (in_mode)
            cpc_pkg::MODE_ACQ: begin
              acq_hit_nxt = (count_r != '0);
              if (count_r != '0) begin
                st_re     = 1'b1;
                st_raddr  = cnt_dec[AW-1:0];
                count_nxt = cnt_dec;
                reuse_nxt = reuse_r + 64'd1;
              end
              state_nxt = S_OP;
            end
            cpc_pkg::MODE_REL: begin
              state_nxt = S_OP;
            end
            cpc_pkg::MODE_PURGE: begin
              n_nxt     = count_r;
              idx_nxt   = '0;
              kept_nxt  = '0;
              nrem_nxt  = '0;
              state_nxt = S_P_RD;
            end
            default: begin
              state_nxt = S_IDLE;
            end
          endcase
        end
      end

      S_OP: begin
        if (out_free) begin
          out_load  = 1'b1;
          state_nxt = S_IDLE;
          if (mode_r == cpc_pkg::MODE_ACQ) begin
            res_nxt.kind = cpc_pkg::KIND_ACQ;
            res_nxt.hit  = acq_hit_r;
            res_nxt.page = acq_hit_r ? st_rdata[PW-1:0] : '0;
          end else begin
            res_nxt.kind = cpc_pkg::KIND_REL;
            if (page_r == '0) begin
              res_nxt.hit = 1'b0;
            end else if (count_r < cap_eff) begin
              st_we          = 1'b1;
              st_waddr       = count_r[AW-1:0];
              st_wdata       = {now_r, page_r};
              count_nxt      = cnt_inc;
              res_nxt.hit    = 1'b1;
              res_nxt.cached = cnt_inc;
            end else begin
              reject_nxt        = reject_r + 64'd1;
              res_nxt.to_system = 1'b1;
              res_nxt.page      = page_r;
            end
          end
        end
      end

      // first read of the sweep
      S_P_RD: begin
        if (idx_r == n_r) begin
          state_nxt = S_P_FIN;
        end else begin
          st_re     = 1'b1;
          st_raddr  = idx_r[AW-1:0];
          state_nxt = S_P_CMP;
        end
      end

      S_P_CMP: begin
        state_nxt = S_P_WR;
      end

      // sort the entry, fetch the next one
      S_P_WR: begin
        if (age_expired) begin
          sp_we    = 1'b1;
          nrem_nxt = nrem_r + CW'(1);
        end else begin
          st_we    = 1'b1;
          st_waddr = kept_r[AW-1:0];
          kept_nxt = kept_r + CW'(1);
        end
        idx_nxt = idx_inc;
        if (idx_inc == n_r) begin
          state_nxt = S_P_FIN;
        end else begin
          st_re     = 1'b1;
          st_raddr  = idx_inc[AW-1:0];
          state_nxt = S_P_CMP;
        end
      end

      S_P_FIN: begin
        count_nxt  = kept_r;
        purged_nxt = purged_r + 64'(nrem_r);
        emit_nxt   = '0;
        if (nrem_r == '0) begin
          state_nxt = S_P_NONE;
        end else begin
          sp_re     = 1'b1;
          sp_raddr  = '0;
          state_nxt = S_P_EMIT;
        end
      end

      S_P_NONE: begin
        if (out_free) begin
          out_load     = 1'b1;
          res_nxt.kind = cpc_pkg::KIND_NONE;
          state_nxt    = S_IDLE;
        end
      end

      S_P_EMIT: begin
        if (out_free) begin
          out_load          = 1'b1;
          res_nxt.kind      = cpc_pkg::KIND_PURGED;
          res_nxt.to_system = 1'b1;
          res_nxt.page      = sp_rdata;
          res_nxt.seq       = emit_inc;
          res_nxt.last      = (emit_inc == nrem_r);
          emit_nxt          = emit_inc;
          if (emit_inc == nrem_r) begin
            state_nxt = S_IDLE;
          end else begin
            sp_re    = 1'b1;
            sp_raddr = emit_inc[AW-1:0];
          end
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      cap_r       <= CW'(64);
      reuse_r     <= '0;
      reject_r    <= '0;
      purged_r    <= '0;
      out_valid_r <= 1'b0;
      acq_hit_r   <= 1'b0;
      n_r         <= '0;
      idx_r       <= '0;
      kept_r      <= '0;
      nrem_r      <= '0;
      emit_r      <= '0;
    end else begin
      state_r   <= state_nxt;
      count_r   <= count_nxt;
      reuse_r   <= reuse_nxt;
      reject_r  <= reject_nxt;
      purged_r  <= purged_nxt;
      acq_hit_r <= acq_hit_nxt;
      n_r       <= n_nxt;
      idx_r     <= idx_nxt;
      kept_r    <= kept_nxt;
      nrem_r    <= nrem_nxt;
      emit_r    <= emit_nxt;
      if (cfg_valid && cfg_ready) begin
        cap_r <= cfg_data;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // latched item and output word
  always_ff @(posedge clk) begin
    mode_r <= mode_nxt;
    page_r <= page_nxt;
    now_r  <= now_nxt;
    max_r  <= max_nxt;
    if (out_load) begin
      res_r        <= res_nxt;
      tot_reuse_r  <= reuse_nxt;
      tot_reject_r <= reject_nxt;
      tot_purged_r <= purged_nxt;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_kind         = res_r.kind;
  assign out_hit          = res_r.hit;
  assign out_to_system    = res_r.to_system;
  assign out_page_out     = res_r.page;
  assign out_cached_now   = res_r.cached;
  assign out_purge_seq    = res_r.seq;
  assign out_last         = res_r.last;
  assign out_reuse_total  = tot_reuse_r;
  assign out_reject_total = tot_reject_r;
  assign out_purged_total = tot_purged_r;

  // checks
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= DEPTH_C)
    else $error("entry count above depth");

  a_acq_pop: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_mode == cpc_pkg::MODE_ACQ && count_r != '0)
      |=> count_r == $past(count_r) - CW'(1))
    else $error("acquire hit did not pop");

  a_sweep_split: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_P_CMP) |-> (CW'(kept_r + nrem_r) == idx_r))
    else $error("purge sweep lost an entry");

  a_emit_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_P_EMIT) |-> (emit_r < nrem_r))
    else $error("purge emit index past removed count");

endmodule

### design/cpc_ram.sv
module cpc_ram #(
  parameter int WIDTH  = 8,
  parameter int DEPTH  = 64,
  parameter int ADDR_W = 6
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### design/cpc_age_unit.sv
module cpc_age_unit (
  input  logic                      clk,
  input  logic [cpc_pkg::TIME_W-1:0] now_time,
  input  logic [cpc_pkg::TIME_W-1:0] stamp,
  input  logic [cpc_pkg::TIME_W-1:0] limit,
  output logic                      expired_r
);

  logic [cpc_pkg::TIME_W-1:0] age;
  logic                       expired_nxt;

  // wrapping age, then compare against the idle limit
  always_comb begin
    age         = now_time - stamp;
    expired_nxt = (age >= limit);
  end

  always_ff @(posedge clk) begin
    expired_r <= expired_nxt;
  end

endmodule

### test/tb_capped_page_cache_with_idle_purge_top.sv
`timescale 1ns / 100ps

module tb_capped_page_cache_with_idle_purge_top;

  // sizes from the package
  localparam int TIME_W     = cpc_pkg::TIME_W;
  localparam int PAGE_W     = cpc_pkg::PAGE_W;
  localparam int CNT_W      = cpc_pkg::CNT_W;
  localparam int TOT_W      = cpc_pkg::TOT_W;
  localparam int POOL_DEPTH = cpc_pkg::POOL_DEPTH;

  // mode 3 has no meaning; the block must drop it
  localparam logic [1:0] MODE_UNUSED = 2'd3;
  localparam int QUIET_CYCLES = 8;
  localparam int DRAIN_LIMIT  = 20000;
  localparam int PHASE_ITEMS  = 100;
  localparam logic [TIME_W-1:0] TIME_ONES = {TIME_W{1'b1}};
  localparam logic [PAGE_W-1:0] PAGE_ONES = {PAGE_W{1'b1}};

  // one result word as the block should send it
  typedef struct packed {
    logic [1:0]        kind;
    logic              hit;
    logic              to_system;
    logic [PAGE_W-1:0] page;
    logic [CNT_W-1:0]  cached;
    logic [CNT_W-1:0]  seq;
    logic              last;
    logic [TOT_W-1:0]  reuse;
    logic [TOT_W-1:0]  reject;
    logic [TOT_W-1:0]  purged;
  } cache_word_t;

  typedef enum logic {ROW_ITEM, ROW_CAP} row_op_t;

  // directed stimulus row
  typedef struct packed {
    row_op_t           op;
    logic [1:0]        mode;
    logic [PAGE_W-1:0] page;
    logic [TIME_W-1:0] now;
    logic [TIME_W-1:0] idle;
    logic [CNT_W-1:0]  cap;
    logic              typed;
    cache_word_t       want;
  } plan_row_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic [1:0]        in_mode = cpc_pkg::MODE_ACQ;
  logic [PAGE_W-1:0] in_page_number = '0;
  logic [TIME_W-1:0] in_now_time = '0;
  logic [TIME_W-1:0] in_max_idle = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [1:0]        out_kind;
  logic              out_hit;
  logic              out_to_system;
  logic [PAGE_W-1:0] out_page_out;
  logic [CNT_W-1:0]  out_cached_now;
  logic [CNT_W-1:0]  out_purge_seq;
  logic              out_last;
  logic [TOT_W-1:0]  out_reuse_total;
  logic [TOT_W-1:0]  out_reject_total;
  logic [TOT_W-1:0]  out_purged_total;
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic [CNT_W-1:0]  cfg_data = '0;

  // shadow of the cache
  logic [PAGE_W-1:0] page_mem  [POOL_DEPTH];
  logic [TIME_W-1:0] stamp_mem [POOL_DEPTH];
  int                held = 0;
  logic [TOT_W-1:0]  reuse_cnt = '0;
  logic [TOT_W-1:0]  reject_cnt = '0;
  logic [TOT_W-1:0]  purge_cnt = '0;
  logic [CNT_W-1:0]  cap_reg = CNT_W'(64);

  cache_word_t       exp_words[$];
  cache_word_t       got_want;
  int                mismatch_cnt = 0;
  int                send_idle_pct = 25;
  int                recv_stall_pct = 45;
  logic [TIME_W-1:0] t_now = '0;

  capped_page_cache_with_idle_purge_top u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_mode          (in_mode),
    .in_page_number   (in_page_number),
    .in_now_time      (in_now_time),
    .in_max_idle      (in_max_idle),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_kind         (out_kind),
    .out_hit          (out_hit),
    .out_to_system    (out_to_system),
    .out_page_out     (out_page_out),
    .out_cached_now   (out_cached_now),
    .out_purge_seq    (out_purge_seq),
    .out_last         (out_last),
    .out_reuse_total  (out_reuse_total),
    .out_reject_total (out_reject_total),
    .out_purged_total (out_purged_total),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_data         (cfg_data)
  );

  always #5 clk = ~clk;

  // receiver back-pressure
  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  // next expected cache words for one accepted request
  task automatic cache_predict(input logic [1:0] mode, input logic [PAGE_W-1:0] page_in,
                               input logic [TIME_W-1:0] now, input logic [TIME_W-1:0] idle);
    logic [PAGE_W-1:0] gone [POOL_DEPTH];
    logic [PAGE_W-1:0] page;
    logic [TIME_W-1:0] age;
    cache_word_t       w;
    int                n_gone;
    int                kept;
    int                lim;
    int                i;
    w = '0;
    w.last = 1'b1;
    n_gone = 0;
    kept = 0;
    page = page_in & cpc_pkg::PAGE_MASK;
    lim = (cap_reg > POOL_DEPTH) ? POOL_DEPTH : int'(cap_reg);
    case (mode)
      cpc_pkg::MODE_ACQ: begin
        w.kind = cpc_pkg::KIND_ACQ;
        if (held > 0) begin
          held--;
          w.hit = 1'b1;
          w.page = page_mem[held];
          reuse_cnt++;
        end
      end
      cpc_pkg::MODE_REL: begin
        w.kind = cpc_pkg::KIND_REL;
        // page zero is a no-op release
        if (page != '0) begin
          if (held < lim) begin
            page_mem[held] = page;
            stamp_mem[held] = now;
            held++;
            w.hit = 1'b1;
          end else begin
            reject_cnt++;
            w.to_system = 1'b1;
            w.page = page;
          end
        end
      end
      cpc_pkg::MODE_PURGE: begin
        // age wraps at 64 bits; survivors keep their order
        for (i = 0; i < held; i++) begin
          age = now - stamp_mem[i];
          if (age >= idle) begin
            gone[n_gone] = page_mem[i];
            n_gone++;
          end else begin
            page_mem[kept] = page_mem[i];
            stamp_mem[kept] = stamp_mem[i];
            kept++;
          end
        end
        held = kept;
        purge_cnt = purge_cnt + TOT_W'(n_gone);
        w.kind = (n_gone == 0) ? cpc_pkg::KIND_NONE : cpc_pkg::KIND_PURGED;
      end
      default: return;
    endcase
    w.cached = CNT_W'(held);
    w.reuse = reuse_cnt;
    w.reject = reject_cnt;
    w.purged = purge_cnt;
    if (n_gone != 0) begin
      for (i = 0; i < n_gone; i++) begin
        w.to_system = 1'b1;
        w.page = gone[i];
        w.seq = CNT_W'(i + 1);
        w.last = (i + 1 == n_gone);
        exp_words.push_back(w);
      end
    end else begin
      exp_words.push_back(w);
    end
  endtask

  // offer one request word, hold it through stalls
  task automatic push_word(input logic [1:0] mode, input logic [PAGE_W-1:0] page,
                           input logic [TIME_W-1:0] now, input logic [TIME_W-1:0] idle);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_mode        <= mode;
    in_page_number <= page;
    in_now_time    <= now;
    in_max_idle    <= idle;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    cache_predict(mode, page, now, idle);
  endtask

  // hold off until every expected word is back and the block has settled
  task automatic quiet_wait();
    in_valid <= 1'b0;
    while (exp_words.size() != 0) @(posedge clk);
    repeat (QUIET_CYCLES) @(posedge clk);
  endtask

  task automatic write_cap(input logic [CNT_W-1:0] v);
    quiet_wait();
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    cap_reg = v;
  endtask

  task automatic cmp_field(input string name, input logic [63:0] want, input logic [63:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      mismatch_cnt++;
    end
  endtask

  // result checker
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (exp_words.size() == 0) begin
        $error("unexpected result word, kind %0d page %0h", out_kind, out_page_out);
        mismatch_cnt++;
      end else begin
        got_want = exp_words.pop_front();
        cmp_field("kind", 64'(got_want.kind), 64'(out_kind));
        cmp_field("hit", 64'(got_want.hit), 64'(out_hit));
        cmp_field("to_system", 64'(got_want.to_system), 64'(out_to_system));
        cmp_field("page_out", 64'(got_want.page), 64'(out_page_out));
        cmp_field("cached_now", 64'(got_want.cached), 64'(out_cached_now));
        cmp_field("purge_seq", 64'(got_want.seq), 64'(out_purge_seq));
        cmp_field("last", 64'(got_want.last), 64'(out_last));
        cmp_field("reuse_total", got_want.reuse, out_reuse_total);
        cmp_field("reject_total", got_want.reject, out_reject_total);
        cmp_field("purged_total", got_want.purged, out_purged_total);
      end
    end
  end

  function automatic logic [63:0] rand_wide();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [PAGE_W-1:0] rand_page();
    logic [63:0] x;
    x = rand_wide();
    if (x[PAGE_W-1:0] == '0) x[0] = 1'b1;
    return x[PAGE_W-1:0];
  endfunction

  // mostly a slowly advancing clock, now and then anything
  function automatic logic [TIME_W-1:0] next_stamp();
    if ($urandom_range(99) < 85) begin
      t_now = t_now + TIME_W'($urandom_range(0, 40));
      return t_now;
    end
    return rand_wide();
  endfunction

  function automatic logic [TIME_W-1:0] pick_idle();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return TIME_ONES;
      2: return rand_wide();
      default: return TIME_W'($urandom_range(0, 600));
    endcase
  endfunction

  function automatic plan_row_t item_row(logic [1:0] m, logic [PAGE_W-1:0] p,
                                         logic [TIME_W-1:0] t, logic [TIME_W-1:0] d);
    plan_row_t r;
    r = '0;
    r.op = ROW_ITEM;
    r.mode = m;
    r.page = p;
    r.now = t;
    r.idle = d;
    return r;
  endfunction

  function automatic plan_row_t cap_row(logic [CNT_W-1:0] v);
    plan_row_t r;
    r = '0;
    r.op = ROW_CAP;
    r.cap = v;
    return r;
  endfunction

  // right after reset every reply is all zero but kind and last
  function automatic plan_row_t typed_row(logic [1:0] m, logic [PAGE_W-1:0] p,
                                          logic [TIME_W-1:0] t, logic [1:0] k);
    plan_row_t r;
    r = item_row(m, p, t, '0);
    r.typed = 1'b1;
    r.want.kind = k;
    r.want.last = 1'b1;
    return r;
  endfunction

  // random traffic: mostly fill / drain / purge runs, some noise
  task automatic run_phase(input int target);
    int               done_items;
    int               pick;
    int               n;
    int               k;
    logic [1:0]       m;
    logic [PAGE_W-1:0] p;
    done_items = 0;
    while (done_items < target) begin
      pick = $urandom_range(99);
      if (pick < 30) begin
        n = ($urandom_range(99) < 70) ? $urandom_range(1, 8) : $urandom_range(9, 70);
        for (k = 0; k < n; k++) begin
          push_word(cpc_pkg::MODE_REL, rand_page(), next_stamp(), rand_wide());
        end
        done_items += n;
      end else if (pick < 50) begin
        n = $urandom_range(1, 20);
        for (k = 0; k < n; k++) begin
          push_word(cpc_pkg::MODE_ACQ, rand_page(), rand_wide(), rand_wide());
        end
        done_items += n;
      end else if (pick < 70) begin
        push_word(cpc_pkg::MODE_PURGE, rand_page(), t_now + TIME_W'($urandom_range(0, 100)),
                  pick_idle());
        done_items++;
      end else if (pick < 92) begin
        m = 2'($urandom_range(0, 3));
        p = ($urandom_range(0, 3) == 0) ? '0 : rand_page();
        push_word(m, p, rand_wide(), rand_wide());
        if (m != MODE_UNUSED) done_items++;
      end else begin
        // let everything drain, maybe retune the cap, then sweep
        quiet_wait();
        if ($urandom_range(1) == 1) write_cap(CNT_W'($urandom_range(0, 127)));
        push_word(cpc_pkg::MODE_PURGE, rand_page(), next_stamp(), pick_idle());
        done_items++;
      end
    end
  endtask

  // main sequence
  initial begin
    plan_row_t plan[$];
    int        ph;
    int        guard;

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed part: replies after reset, extremes, cap corner cases
    plan.push_back(typed_row(cpc_pkg::MODE_ACQ, PAGE_ONES, TIME_ONES, cpc_pkg::KIND_ACQ));
    plan.push_back(typed_row(cpc_pkg::MODE_REL, '0, TIME_ONES, cpc_pkg::KIND_REL));
    plan.push_back(typed_row(cpc_pkg::MODE_PURGE, PAGE_ONES, TIME_ONES, cpc_pkg::KIND_NONE));
    plan.push_back(item_row(MODE_UNUSED, PAGE_ONES, TIME_ONES, TIME_ONES));
    plan.push_back(item_row(cpc_pkg::MODE_REL, PAGE_ONES, '0, '0));
    plan.push_back(item_row(cpc_pkg::MODE_REL, PAGE_W'(1), TIME_ONES, TIME_ONES));
    plan.push_back(item_row(cpc_pkg::MODE_REL, {13{4'h5}}, TIME_W'(100), '0));
    plan.push_back(item_row(cpc_pkg::MODE_ACQ, '0, '0, '0));
    plan.push_back(item_row(cpc_pkg::MODE_REL, {13{4'hA}}, TIME_W'(200), '0));
    // wrapped age of the newest entry is just under the limit: nothing goes
    plan.push_back(item_row(cpc_pkg::MODE_PURGE, '0, TIME_W'(150), TIME_ONES));
    plan.push_back(item_row(cpc_pkg::MODE_PURGE, '0, TIME_W'(150), TIME_W'(151)));
    plan.push_back(item_row(cpc_pkg::MODE_REL, PAGE_W'(2), '0, '0));
    plan.push_back(item_row(cpc_pkg::MODE_PURGE, '0, TIME_W'(5), '0));
    plan.push_back(item_row(cpc_pkg::MODE_ACQ, '0, '0, '0));
    plan.push_back(cap_row(CNT_W'(0)));
    plan.push_back(item_row(cpc_pkg::MODE_REL, PAGE_W'(7), TIME_W'(10), '0));
    plan.push_back(cap_row(CNT_W'(2)));
    plan.push_back(item_row(cpc_pkg::MODE_REL, PAGE_W'(8), TIME_W'(11), '0));
    plan.push_back(item_row(cpc_pkg::MODE_REL, PAGE_W'(9), TIME_W'(12), '0));
    plan.push_back(item_row(cpc_pkg::MODE_REL, PAGE_W'(10), TIME_W'(13), '0));
    // cap below the count: entries stay, releases bounce
    plan.push_back(cap_row(CNT_W'(1)));
    plan.push_back(item_row(cpc_pkg::MODE_REL, PAGE_W'(11), TIME_W'(14), '0));
    plan.push_back(item_row(cpc_pkg::MODE_ACQ, '0, '0, '0));
    plan.push_back(item_row(cpc_pkg::MODE_ACQ, '0, '0, '0));
    plan.push_back(item_row(cpc_pkg::MODE_ACQ, '0, '0, '0));
    plan.push_back(item_row(cpc_pkg::MODE_REL, PAGE_W'(12), TIME_W'(15), '0));
    plan.push_back(item_row(cpc_pkg::MODE_REL, PAGE_W'(13), TIME_W'(16), '0));
    plan.push_back(cap_row(CNT_W'(127)));

    foreach (plan[r]) begin
      if (plan[r].op == ROW_CAP) begin
        write_cap(plan[r].cap);
      end else begin
        push_word(plan[r].mode, plan[r].page, plan[r].now, plan[r].idle);
        if (plan[r].typed) begin
          void'(exp_words.pop_back());
          exp_words.push_back(plan[r].want);
        end
      end
    end

    // random part in three idling regimes
    t_now = TIME_W'(1000);
    for (ph = 0; ph < 3; ph++) begin
      case (ph)
        0: begin
          send_idle_pct = 25;
          recv_stall_pct = 45;
          write_cap(CNT_W'(64));
        end
        1: begin
          send_idle_pct = 45;
          recv_stall_pct = 25;
          write_cap(CNT_W'($urandom_range(1, 40)));
        end
        default: begin
          send_idle_pct = 0;
          recv_stall_pct = 0;
          write_cap(CNT_W'(127));
        end
      endcase
      run_phase(PHASE_ITEMS);
    end

    // drain and settle
    in_valid <= 1'b0;
    guard = 0;
    while (exp_words.size() != 0 && guard < DRAIN_LIMIT) begin
      @(posedge clk);
      guard++;
    end
    repeat (QUIET_CYCLES * 4) @(posedge clk);
    if (exp_words.size() != 0) begin
      $error("%0d expected result words never arrived", exp_words.size());
      mismatch_cnt += exp_words.size();
    end

    if (mismatch_cnt == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // watchdog
  initial begin
    #5_000_000;
    $display("Mismatches found");
    $finish;
  end

endmodule
